// ===== rtl/msc_pkg.sv =====
// Shared types and constants for the masked share conversion block.
`timescale 1ns / 1ps

package msc_pkg;

   // Width of every word field on the ports.
   localparam int FIELD_BITS = 32;

   // Conversion selector.
   typedef enum logic [0:0] {
      OP_B2A = 1'b0,   // XOR mask to subtractive mask
      OP_A2B = 1'b1    // subtractive mask to XOR mask
   } op_type;

endpackage

// ===== rtl/msc_entry.sv =====
// Entry stage: Boolean-to-arithmetic conversion and carry recurrence setup.
`timescale 1ns / 1ps

module msc_entry #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic                 in_op,
   input  logic [WORD_BITS-1:0] in_value,
   input  logic [WORD_BITS-1:0] in_mask,
   input  logic [WORD_BITS-1:0] in_random,
   output logic                 out_valid,
   output logic [WORD_BITS-1:0] out_carry,
   output logic [WORD_BITS-1:0] out_inv,
   output logic [WORD_BITS-1:0] out_mask,
   output logic [WORD_BITS-1:0] out_value,
   output logic [WORD_BITS-1:0] out_partial
);

   logic                 valid_ff;
   logic [WORD_BITS-1:0] carry_ff, inv_ff, mask_ff, value_ff, partial_ff;
   logic [WORD_BITS-1:0] carry_in, inv_in, partial_in;

   // Boolean to arithmetic terms
   logic [WORD_BITS-1:0] b2a_t, b2a_g2, b2a_res;
   // Arithmetic to Boolean setup terms
   logic [WORD_BITS-1:0] a2b_t0, a2b_xb, a2b_g, a2b_om;
   logic                 is_a2b;

   always_comb begin
      is_a2b  = (in_op == msc_pkg::OP_A2B);

      // two independent subtractions, joined by XOR
      b2a_g2  = in_random ^ in_mask;
      b2a_t   = ((in_value ^ in_random) - in_random) ^ in_value;
      b2a_res = ((in_value ^ b2a_g2) - b2a_g2) ^ b2a_t;

      a2b_t0  = {in_random[WORD_BITS-2:0], 1'b0};
      a2b_xb  = a2b_t0 ^ in_value;
      a2b_g   = (in_random ^ a2b_xb) & in_mask;
      a2b_om  = (in_random & (in_random ^ in_mask)) ^ a2b_g ^ (a2b_t0 & in_value);

      // zero carry and invariant term let a B2A item ride the chain unchanged
      carry_in   = is_a2b ? a2b_t0 : '0;
      inv_in     = is_a2b ? a2b_om : '0;
      partial_in = is_a2b ? a2b_xb : b2a_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         carry_ff   <= carry_in;
         inv_ff     <= inv_in;
         mask_ff    <= in_mask;
         value_ff   <= in_value;
         partial_ff <= partial_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_carry   = carry_ff;
   assign out_inv     = inv_ff;
   assign out_mask    = mask_ff;
   assign out_value   = value_ff;
   assign out_partial = partial_ff;

endmodule

// ===== rtl/msc_cell.sv =====
// One step of the masked carry recurrence, registered.
`timescale 1ns / 1ps

module msc_cell #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [WORD_BITS-1:0] in_carry,
   input  logic [WORD_BITS-1:0] in_inv,
   input  logic [WORD_BITS-1:0] in_mask,
   input  logic [WORD_BITS-1:0] in_value,
   input  logic [WORD_BITS-1:0] in_partial,
   output logic                 out_valid,
   output logic [WORD_BITS-1:0] out_carry,
   output logic [WORD_BITS-1:0] out_inv,
   output logic [WORD_BITS-1:0] out_mask,
   output logic [WORD_BITS-1:0] out_value,
   output logic [WORD_BITS-1:0] out_partial
);

   logic                 valid_ff;
   logic [WORD_BITS-1:0] carry_ff, inv_ff, mask_ff, value_ff, partial_ff;
   logic [WORD_BITS-1:0] gen;
   logic [WORD_BITS-1:0] carry_in;

   always_comb begin
      gen      = (in_carry & in_mask) ^ in_inv ^ (in_carry & in_value);
      carry_in = {gen[WORD_BITS-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         carry_ff   <= carry_in;
         inv_ff     <= in_inv;
         mask_ff    <= in_mask;
         value_ff   <= in_value;
         partial_ff <= in_partial;
      end
   end

   assign out_valid   = valid_ff;
   assign out_carry   = carry_ff;
   assign out_inv     = inv_ff;
   assign out_mask    = mask_ff;
   assign out_value   = value_ff;
   assign out_partial = partial_ff;

endmodule

// ===== rtl/msc_out.sv =====
// Output register with one skid entry.
`timescale 1ns / 1ps

module msc_out (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [msc_pkg::FIELD_BITS-1:0] in_value,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [msc_pkg::FIELD_BITS-1:0] rsp_value,
   output logic                           hold
);

   logic                           out_valid_ff, out_valid_in;
   logic                           skid_valid_ff, skid_valid_in;
   logic [msc_pkg::FIELD_BITS-1:0] out_value_ff, out_value_in;
   logic [msc_pkg::FIELD_BITS-1:0] skid_value_ff, skid_value_in;
   logic                           take;

   always_comb begin
      take          = out_valid_ff && !rsp_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_value_in  = out_value_ff;
      skid_value_in = skid_value_ff;
      if (skid_valid_ff) begin
         // chain is frozen; drain the skid entry
         if (take) begin
            out_value_in  = skid_value_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_value_in = in_value;
            out_valid_in = 1'b1;
         end else begin
            skid_value_in = in_value;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      skid_value_ff <= skid_value_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_value = out_value_ff;
   assign hold      = skid_valid_ff;

endmodule

// ===== rtl/masked_share_conversion.sv =====
// Top level of the Boolean/arithmetic masked share conversion pipeline.
`timescale 1ns / 1ps

// Channel  Ports                                         Direction  Moves
// req      req_valid req_stall req_op req_masked_value  in         one item to convert
//          req_mask req_fresh_random
// rsp      rsp_valid rsp_stall rsp_converted_value       out        one converted item
//
// Rate: one item per cycle while the skid entry is empty; items do not depend on each other.
// Path: an accepted item is registered in the entry stage, then in WORD_BITS-1 recurrence
//   cells, then in the output register; the number of cells is set by the carry chain.
// Reset (synchronous) empties the chain, the output register and the skid entry.
// A stalled result parks the next item in a one-entry skid buffer; only while that
//   entry is full do the chain and req_stall hold.

module masked_share_conversion #(
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_masked_value,
   input  logic [31:0] req_mask,
   input  logic [31:0] req_fresh_random,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_converted_value
);

   localparam int FieldBits = msc_pkg::FIELD_BITS;
   localparam int Cells     = WORD_BITS - 1;

   logic                 advance;   // whole chain moves together
   logic                 hold;      // skid entry occupied

   // Word-width view of the input fields (zero-extended or cut to WORD_BITS)
   logic [WORD_BITS-1:0] in_value, in_mask, in_random;

   // Chain links: index 0 is the entry stage, index k the output of cell k
   logic                 valid_chain   [0:Cells];
   logic [WORD_BITS-1:0] carry_chain   [0:Cells];
   logic [WORD_BITS-1:0] inv_chain     [0:Cells];
   logic [WORD_BITS-1:0] mask_chain    [0:Cells];
   logic [WORD_BITS-1:0] value_chain   [0:Cells];
   logic [WORD_BITS-1:0] partial_chain [0:Cells];

   logic [WORD_BITS-1:0] result;

   assign in_value  = WORD_BITS'(req_masked_value);
   assign in_mask   = WORD_BITS'(req_mask);
   assign in_random = WORD_BITS'(req_fresh_random);

   // The chain only freezes when the skid entry is full, so stall is a register.
   assign advance   = !hold;
   assign req_stall = hold;

   // Entry: B2A finishes here; A2B gets its first carry and loop invariant.
   msc_entry #(
      .WORD_BITS (WORD_BITS)
   ) u_entry (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .in_op       (req_op),
      .in_value    (in_value),
      .in_mask     (in_mask),
      .in_random   (in_random),
      .out_valid   (valid_chain[0]),
      .out_carry   (carry_chain[0]),
      .out_inv     (inv_chain[0]),
      .out_mask    (mask_chain[0]),
      .out_value   (value_chain[0]),
      .out_partial (partial_chain[0])
   );

   // One recurrence step per cell. B2A items carry a zero carry and invariant,
   // so the carry stays zero and the finished result passes straight through.
   for (genvar k = 1; k <= Cells; k++) begin : g_cell
      msc_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_valid    (valid_chain[k-1]),
         .in_carry    (carry_chain[k-1]),
         .in_inv      (inv_chain[k-1]),
         .in_mask     (mask_chain[k-1]),
         .in_value    (value_chain[k-1]),
         .in_partial  (partial_chain[k-1]),
         .out_valid   (valid_chain[k]),
         .out_carry   (carry_chain[k]),
         .out_inv     (inv_chain[k]),
         .out_mask    (mask_chain[k]),
         .out_value   (value_chain[k]),
         .out_partial (partial_chain[k])
      );
   end

   // Final XOR of the partial word with the last carry
   assign result = partial_chain[Cells] ^ carry_chain[Cells];

   msc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_chain[Cells]),
      .in_value  (FieldBits'(result)),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_value (rsp_converted_value),
      .hold      (hold)
   );

endmodule

// ===== rtl/msc_checker.sv =====
// Port-level checks for masked_share_conversion, bound to the top level.
`timescale 1ns / 1ps

module msc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_converted_value
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_converted_value))
      else $error("stalled item changed");

   // input backpressure only while a result is waiting
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending result");

   // skid entry fills only behind a stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall rose without output stall");

   // one taken result frees the skid entry
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      req_stall && !rsp_stall |=> !req_stall)
      else $error("req_stall held after result taken");

   // reset empties the block
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("block not empty after reset");

endmodule

bind masked_share_conversion msc_checker u_msc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_converted_value (rsp_converted_value)
);
